@@ hdl/kmp_pkg.sv @@
`timescale 1ns / 1ps

package kmp_pkg;

  // Pattern store geometry
  localparam int PAT_DEPTH = 64;
  localparam int IDX_BITS  = (PAT_DEPTH > 1) ? $clog2(PAT_DEPTH) : 1;
  localparam int CNT_BITS  = $clog2(PAT_DEPTH + 1);

  // Text counter and reported position
  localparam int TC_BITS  = 16;
  localparam int POS_BITS = 16;

  // Operation codes
  localparam logic [1:0] OP_CLEAR  = 2'd0;
  localparam logic [1:0] OP_APPEND = 2'd1;
  localparam logic [1:0] OP_TEXT   = 2'd2;

  typedef struct packed {
    logic [1:0] operation;
    logic [7:0] data_byte;
    logic       end_of_text;
  } kmp_in_t;

  typedef struct packed {
    logic                found;
    logic [POS_BITS-1:0] position;
  } kmp_out_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEED,
    ST_READ,
    ST_CMP,
    ST_FINISH,
    ST_EMIT
  } kmp_state_t;

  // Controller -> datapath
  typedef struct packed {
    logic clear;
    logic append_start;
    logic text_start;
    logic empty_hit;
    logic seed_load;
    logic step;
    logic finish;
    logic load_out;
  } kmp_cmd_t;

  // Datapath -> controller
  typedef struct packed {
    logic pat_full;
    logic pat_empty;
    logic done;
    logic jp_zero;
    logic byte_eq;
    logic fin_result;
    logic out_free;
  } kmp_sts_t;

endpackage

@@ hdl/kmp_ctrl.sv @@
`timescale 1ns / 1ps

module kmp_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic [1:0]        in_op,
  input  kmp_pkg::kmp_sts_t sts,
  output logic              in_stall,
  output kmp_pkg::kmp_cmd_t cmd
);

  kmp_pkg::kmp_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= kmp_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      kmp_pkg::ST_IDLE: begin
        if (in_valid) begin
          case (in_op)
            kmp_pkg::OP_APPEND: begin
              if (!sts.pat_full) state_nxt = kmp_pkg::ST_SEED;
            end
            kmp_pkg::OP_TEXT: begin
              if (!sts.done) begin
                state_nxt = sts.pat_empty ? kmp_pkg::ST_EMIT : kmp_pkg::ST_READ;
              end
            end
            default: state_nxt = kmp_pkg::ST_IDLE;
          endcase
        end
      end
      kmp_pkg::ST_SEED:   state_nxt = kmp_pkg::ST_READ;
      kmp_pkg::ST_READ:   state_nxt = sts.jp_zero ? kmp_pkg::ST_FINISH : kmp_pkg::ST_CMP;
      kmp_pkg::ST_CMP:    state_nxt = sts.byte_eq ? kmp_pkg::ST_FINISH : kmp_pkg::ST_READ;
      kmp_pkg::ST_FINISH: state_nxt = sts.fin_result ? kmp_pkg::ST_EMIT : kmp_pkg::ST_IDLE;
      kmp_pkg::ST_EMIT: begin
        if (sts.out_free) state_nxt = kmp_pkg::ST_IDLE;
      end
      default:            state_nxt = kmp_pkg::ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    logic accept;
    accept           = (state_r == kmp_pkg::ST_IDLE) && in_valid;
    in_stall         = (state_r != kmp_pkg::ST_IDLE);
    cmd              = '0;
    cmd.clear        = accept && (in_op == kmp_pkg::OP_CLEAR);
    cmd.append_start = accept && (in_op == kmp_pkg::OP_APPEND) && !sts.pat_full;
    cmd.text_start   = accept && (in_op == kmp_pkg::OP_TEXT) && !sts.done &&
                       !sts.pat_empty;
    cmd.empty_hit    = accept && (in_op == kmp_pkg::OP_TEXT) && !sts.done &&
                       sts.pat_empty;
    cmd.seed_load    = (state_r == kmp_pkg::ST_SEED);
    cmd.step         = (state_r == kmp_pkg::ST_CMP);
    cmd.finish       = (state_r == kmp_pkg::ST_FINISH);
    cmd.load_out     = (state_r == kmp_pkg::ST_EMIT) && sts.out_free;
  end

endmodule

@@ hdl/kmp_datapath.sv @@
`timescale 1ns / 1ps

module kmp_datapath (
  input  logic              clk,
  input  logic              rst_n,
  input  kmp_pkg::kmp_in_t  in_data,
  input  kmp_pkg::kmp_cmd_t cmd,
  output kmp_pkg::kmp_sts_t sts,
  input  logic              out_stall,
  output logic              out_valid,
  output kmp_pkg::kmp_out_t out_data
);

  localparam int CB = kmp_pkg::CNT_BITS;
  localparam int IB = kmp_pkg::IDX_BITS;
  localparam int TB = kmp_pkg::TC_BITS;

  // memories: pattern bytes, and links s[k] = failure_link[k] + 1 for k >= 1
  // (s[0] is the constant 0, i.e. link -1)
  logic [7:0]    pat_mem  [kmp_pkg::PAT_DEPTH];
  logic [CB-1:0] link_mem [kmp_pkg::PAT_DEPTH];

  logic [CB-1:0] pat_cnt_r, pat_cnt_nxt;
  logic [CB-1:0] match_r, match_nxt;
  logic [TB-1:0] tc_r, tc_nxt;
  logic          done_r, done_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic [CB-1:0] jp_r, jp_nxt;    // walk index plus one; 0 means index -1
  logic [7:0]    byte_r;
  logic          last_r;
  logic          is_text_r;
  kmp_pkg::kmp_out_t res_r, out_data_r;
  logic [7:0]    pat_rd_r;
  logic [CB-1:0] link_rd_r;
  logic          link_zero_r;

  logic [CB-1:0] jp_m1;
  logic [CB-1:0] link_x;
  logic [CB-1:0] link_x_m1;
  logic [CB-1:0] link_val;
  logic          hit;
  logic [TB-1:0] pos_full;

  assign jp_m1     = jp_r - CB'(1);
  assign link_x    = cmd.append_start ? pat_cnt_r : jp_m1;
  assign link_x_m1 = link_x - CB'(1);
  assign link_val  = link_zero_r ? '0 : link_rd_r;
  assign hit       = (jp_r == pat_cnt_r);
  assign pos_full  = tc_r - TB'(pat_cnt_r) + TB'(1);

  // memory ports
  // at the end of an append walk jp_r holds the new failure link itself,
  // so the stored s[k] is one above it
  always_ff @(posedge clk) begin
    if (cmd.append_start) begin
      pat_mem[pat_cnt_r[IB-1:0]] <= in_data.data_byte;
    end
    if (cmd.finish && !is_text_r) begin
      link_mem[pat_cnt_r[IB-1:0]] <= jp_r + CB'(1);
    end
    pat_rd_r    <= pat_mem[jp_m1[IB-1:0]];
    link_rd_r   <= link_mem[link_x_m1[IB-1:0]];
    link_zero_r <= (link_x == '0);
  end

  always_comb begin
    pat_cnt_nxt   = pat_cnt_r;
    match_nxt     = match_r;
    tc_nxt        = tc_r;
    done_nxt      = done_r;
    jp_nxt        = jp_r;
    out_valid_nxt = out_valid_r && out_stall;
    if (cmd.load_out) out_valid_nxt = 1'b1;
    if (cmd.clear) begin
      pat_cnt_nxt = '0;
      match_nxt   = '0;
      tc_nxt      = '0;
      done_nxt    = 1'b0;
    end
    if (cmd.text_start) begin
      if (tc_r != '1) tc_nxt = tc_r + TB'(1);
      jp_nxt = (match_r >= pat_cnt_r) ? CB'(1) : match_r + CB'(1);
    end
    if (cmd.empty_hit) done_nxt = 1'b1;
    if (cmd.seed_load) jp_nxt = link_val;
    if (cmd.step && (pat_rd_r != byte_r)) jp_nxt = link_val;
    if (cmd.finish) begin
      if (is_text_r) begin
        match_nxt = jp_r;
        if (hit || last_r) done_nxt = 1'b1;
      end else begin
        pat_cnt_nxt = pat_cnt_r + CB'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pat_cnt_r   <= '0;
      match_r     <= '0;
      tc_r        <= '0;
      done_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      pat_cnt_r   <= pat_cnt_nxt;
      match_r     <= match_nxt;
      tc_r        <= tc_nxt;
      done_r      <= done_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    jp_r <= jp_nxt;
    if (cmd.append_start || cmd.text_start) begin
      byte_r    <= in_data.data_byte;
      last_r    <= in_data.end_of_text;
      is_text_r <= cmd.text_start;
    end
    if (cmd.empty_hit) begin
      res_r.found    <= 1'b1;
      res_r.position <= kmp_pkg::POS_BITS'(1);
    end else if (cmd.finish) begin
      res_r.found    <= hit;
      res_r.position <= hit ? kmp_pkg::POS_BITS'(pos_full) : '0;
    end
    if (cmd.load_out) out_data_r <= res_r;
  end

  assign sts.pat_full   = (pat_cnt_r >= CB'(kmp_pkg::PAT_DEPTH));
  assign sts.pat_empty  = (pat_cnt_r == '0);
  assign sts.done       = done_r;
  assign sts.jp_zero    = (jp_r == '0);
  assign sts.byte_eq    = (pat_rd_r == byte_r);
  assign sts.fin_result = is_text_r && (hit || last_r);
  assign sts.out_free   = !out_valid_r || !out_stall;

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // pattern count stays within the store
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    pat_cnt_r <= CB'(kmp_pkg::PAT_DEPTH))
    else $error("pattern count beyond store depth");

  // a walk never starts a read past the stored pattern
  a_walk_range: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.step || cmd.finish) |-> (jp_r <= pat_cnt_r))
    else $error("walk index beyond pattern");

  // text counter saturates, never wraps to zero
  a_tc_sat: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.text_start && tc_r != '0) |=> (tc_r != '0))
    else $error("text counter wrapped");

  // a result is loaded only into a free output slot
  a_out_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> (!out_valid_r || !out_stall))
    else $error("output overwritten while pending");

endmodule

@@ hdl/kmp_substring_search.sv @@
`timescale 1ns / 1ps

// KMP substring search: first occurrence of a byte pattern in a byte stream.
// Input channel (in_valid / in_stall / in_data): one transaction carries an
// operation: clear, append pattern byte, or text byte (end_of_text marks the
// last text byte). Output channel (out_valid / out_stall / out_data): at most
// one transaction per search, found=1 with the 1-based match start, or
// found=0 / position 0 when the marked last byte ends the search unmatched.
// Items are handled one at a time; in_stall is high while an item is in work.
// An append or text byte walks the failure links: each step is a registered
// link read (ST_READ) plus a compare (ST_CMP), and the compare is skipped
// when the walk runs off index 0. An append byte first seeds the walk
// (ST_SEED); both end in ST_FINISH, and a result then passes through ST_EMIT
// into the output register. Clear and ignored items are handled in ST_IDLE.
// Reset empties the pattern and clears the search state and output valid flag; no memory
// clearing pass is needed. When the receiver stalls, the result stays in
// the output register and the next item is still taken; only a further
// result waits until that slot drains.

module kmp_substring_search (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  kmp_pkg::kmp_in_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output kmp_pkg::kmp_out_t out_data
);

  kmp_pkg::kmp_cmd_t cmd;   // controller commands
  kmp_pkg::kmp_sts_t sts;   // datapath status

  // sequencer: decodes the accepted transaction and steps the link walk
  kmp_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_op    (in_data.operation),
    .sts      (sts),
    .in_stall (in_stall),
    .cmd      (cmd)
  );

  // pattern / link memories, counters and the output register
  kmp_datapath u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

@@ tb/tb_kmp_substring_search.sv @@
`timescale 1ns / 1ps

module tb_kmp_substring_search;

  // Operation code the block must ignore
  localparam logic [1:0] OP_UNUSED = 2'd3;

  localparam int MAX_GAP      = 17;     // per-transaction idle draw, both sides
  localparam int HOLD_CYCLES  = 1500;   // long receiver hold-off
  localparam int STALL_LIMIT  = 20000;  // watchdog: cycles with no transaction
  localparam int DRAIN_CYCLES = 300;    // settle time after the last result
  localparam int RANDOM_ITEMS = 1550;
  localparam int RUN_TEXT_LEN = 40;     // back-to-back unmatched run
  localparam longint TEXT_MAX = (64'd1 << kmp_pkg::TC_BITS) - 1;

  typedef struct {
    kmp_pkg::kmp_in_t item;
    int      gap;         // idle cycles before the item is offered
    bit      wait_empty;  // hold the item until every outcome has arrived
  } pending_op_t;

  logic              clk       = 1'b0;
  logic              rst_n     = 1'b0;
  logic              in_valid  = 1'b0;
  logic              in_stall;
  kmp_pkg::kmp_in_t  in_data   = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  kmp_pkg::kmp_out_t out_data;

  kmp_substring_search dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  always #1 clk = ~clk;

  // ---------------------------------------------------------------------
  // Search model: own copy of the pattern, failure links and search state.
  // ---------------------------------------------------------------------
  logic [7:0] pat_bytes [kmp_pkg::PAT_DEPTH];
  int         fail_link [kmp_pkg::PAT_DEPTH + 1];
  int         pat_len;
  int         match_at;
  longint     text_seen;
  bit         search_over;

  kmp_pkg::kmp_out_t expected_outcomes [$];
  pending_op_t       pending_ops [$];

  int  mismatches   = 0;
  int  results_seen = 0;
  int  random_made  = 0;
  bit  calm_tx      = 1'b0;

  task automatic clear_search_model();
    foreach (pat_bytes[i]) pat_bytes[i] = '0;
    foreach (fail_link[i]) fail_link[i] = 0;
    fail_link[0] = -1;
    pat_len      = 0;
    match_at     = 0;
    text_seen    = 0;
    search_over  = 1'b0;
  endtask

  // Advance the model by one accepted transaction; queue the outcome it causes.
  task automatic predict_search_outcome(input kmp_pkg::kmp_in_t t);
    kmp_pkg::kmp_out_t res;
    int                r;
    case (t.operation)
      kmp_pkg::OP_CLEAR: clear_search_model();
      kmp_pkg::OP_APPEND: begin
        // a full store drops the byte
        if (pat_len < kmp_pkg::PAT_DEPTH) begin
          pat_bytes[pat_len] = t.data_byte;
          r = fail_link[pat_len];
          while (r > -1 && pat_bytes[r] != t.data_byte) r = fail_link[r];
          fail_link[pat_len + 1] = r + 1;
          pat_len++;
        end
      end
      kmp_pkg::OP_TEXT: begin
        if (!search_over) begin
          if (pat_len == 0) begin
            // empty pattern matches at the first text byte
            search_over  = 1'b1;
            res.found    = 1'b1;
            res.position = kmp_pkg::POS_BITS'(1);
            expected_outcomes.push_back(res);
          end else begin
            if (text_seen < TEXT_MAX) text_seen++;
            if (match_at < 0 || match_at >= pat_len) match_at = 0;
            while (match_at > -1 && pat_bytes[match_at] != t.data_byte)
              match_at = fail_link[match_at];
            match_at++;
            if (match_at == pat_len) begin
              search_over  = 1'b1;
              res.found    = 1'b1;
              res.position = kmp_pkg::POS_BITS'(text_seen - pat_len + 1);
              expected_outcomes.push_back(res);
            end else if (t.end_of_text) begin
              search_over  = 1'b1;
              res.found    = 1'b0;
              res.position = '0;
              expected_outcomes.push_back(res);
            end
          end
        end
      end
      default: ;  // unused code: no effect
    endcase
  endtask

  task automatic flag_mismatch(input string what);
    $display("[%0t] mismatch: %s", $time, what);
    mismatches++;
  endtask

  // ---------------------------------------------------------------------
  // Stimulus construction
  // ---------------------------------------------------------------------
  task automatic push_op(input logic [1:0] op, input logic [7:0] b, input logic eot,
                         input bit wait_empty);
    pending_op_t p;
    p.item.operation   = op;
    p.item.data_byte   = b;
    p.item.end_of_text = eot;
    p.gap              = calm_tx ? 0 : $urandom_range(0, MAX_GAP);
    p.wait_empty       = wait_empty;
    pending_ops.push_back(p);
    if (op != OP_UNUSED) random_made++;
  endtask

  // One search: clear, pattern, text that often embeds the pattern.
  task automatic add_search(input int search_no);
    logic [7:0] sym [3];
    logic [7:0] pat [$];
    logic [7:0] txt [$];
    logic [7:0] b;
    int         nsym, plen, tlen, at, r, i;
    bit         wild;
    nsym   = $urandom_range(2, 3);
    sym[0] = 8'($urandom_range(0, 255));
    sym[1] = sym[0] ^ (8'd1 << $urandom_range(0, 7));
    sym[2] = 8'($urandom_range(0, 255));
    wild   = ($urandom_range(0, 19) == 0);  // unrestricted bytes, rarely matches
    calm_tx = ($urandom_range(0, 3) == 0);

    // every tenth search waits for the block to drain first
    push_op(kmp_pkg::OP_CLEAR, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
            search_no % 10 == 0);

    r = $urandom_range(0, 99);
    if (r < 4)       plen = 0;
    else if (r < 85) plen = $urandom_range(1, 6);
    else if (r < 96) plen = $urandom_range(7, 20);
    else             plen = $urandom_range(60, 70);   // near or past the store depth; longer patterns spill over
    for (i = 0; i < plen; i++) begin
      b = wild ? 8'($urandom_range(0, 255)) : sym[$urandom_range(0, nsym - 1)];
      pat.push_back(b);
      push_op(kmp_pkg::OP_APPEND, b, 1'($urandom_range(0, 1)), 1'b0);
    end

    tlen = $urandom_range(1, (plen > 30) ? 90 : 40);
    for (i = 0; i < tlen; i++)
      txt.push_back(wild ? 8'($urandom_range(0, 255)) : sym[$urandom_range(0, nsym - 1)]);
    // plant the pattern, sometimes with one bit flipped
    if (plen > 0 && plen <= kmp_pkg::PAT_DEPTH && plen <= tlen &&
        $urandom_range(0, 2) != 0) begin
      at = $urandom_range(0, tlen - plen);
      for (i = 0; i < plen; i++) txt[at + i] = pat[i];
      if ($urandom_range(0, 3) == 0)
        txt[at + $urandom_range(0, plen - 1)] ^= (8'd1 << $urandom_range(0, 7));
    end

    for (i = 0; i < tlen; i++) begin
      if ($urandom_range(0, 19) == 0)
        push_op(kmp_pkg::OP_APPEND, sym[$urandom_range(0, nsym - 1)],
                1'($urandom_range(0, 1)), 1'b0);
      if ($urandom_range(0, 39) == 0)
        push_op(OP_UNUSED, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b0);
      // most searches end with a marked byte; the rest are cut off by the next clear
      push_op(kmp_pkg::OP_TEXT, txt[i], (i == tlen - 1) && ($urandom_range(0, 9) != 0),
              1'b0);
    end
    // trailing text: ignored once the search is over
    if ($urandom_range(0, 4) == 0)
      repeat ($urandom_range(1, 3))
        push_op(kmp_pkg::OP_TEXT, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                1'b0);
  endtask

  task automatic build_stimulus();
    int n;
    // Directed: empty pattern, byte extremes, final-byte match, no match,
    // ignored code, append during a search.
    calm_tx = 1'b0;
    push_op(kmp_pkg::OP_TEXT,   8'h80, 1'b0, 1'b0);  // empty pattern -> found at 1
    push_op(kmp_pkg::OP_TEXT,   8'h7F, 1'b1, 1'b0);  // search over: ignored
    push_op(kmp_pkg::OP_CLEAR,  8'hFF, 1'b1, 1'b0);
    push_op(kmp_pkg::OP_APPEND, 8'h00, 1'b1, 1'b0);
    push_op(kmp_pkg::OP_APPEND, 8'hFF, 1'b0, 1'b0);
    push_op(kmp_pkg::OP_TEXT,   8'hFF, 1'b0, 1'b0);
    push_op(kmp_pkg::OP_TEXT,   8'h00, 1'b0, 1'b0);
    push_op(kmp_pkg::OP_TEXT,   8'hFF, 1'b0, 1'b0);  // match at 2
    push_op(kmp_pkg::OP_TEXT,   8'h00, 1'b1, 1'b0);  // ignored
    push_op(OP_UNUSED,          8'hFF, 1'b1, 1'b0);
    push_op(kmp_pkg::OP_CLEAR,  8'h00, 1'b0, 1'b0);
    push_op(kmp_pkg::OP_APPEND, 8'h41, 1'b0, 1'b0);
    push_op(kmp_pkg::OP_TEXT,   8'h41, 1'b1, 1'b0);  // match on the marked byte
    push_op(kmp_pkg::OP_CLEAR,  8'h00, 1'b0, 1'b0);
    push_op(kmp_pkg::OP_APPEND, 8'h41, 1'b0, 1'b0);
    push_op(kmp_pkg::OP_APPEND, 8'h42, 1'b0, 1'b0);
    push_op(kmp_pkg::OP_TEXT,   8'h43, 1'b1, 1'b0);  // no match -> position 0
    push_op(kmp_pkg::OP_CLEAR,  8'h00, 1'b0, 1'b0);
    push_op(kmp_pkg::OP_APPEND, 8'h61, 1'b0, 1'b0);
    push_op(kmp_pkg::OP_TEXT,   8'h62, 1'b0, 1'b0);
    push_op(kmp_pkg::OP_APPEND, 8'h62, 1'b0, 1'b0);  // pattern grows mid-search
    push_op(kmp_pkg::OP_TEXT,   8'h61, 1'b0, 1'b0);
    push_op(kmp_pkg::OP_TEXT,   8'h62, 1'b1, 1'b0);

    // Full store: a^63 c plus dropped bytes; text forces a walk down the
    // whole link chain before the match.
    push_op(kmp_pkg::OP_CLEAR, 8'h00, 1'b0, 1'b0);
    repeat (kmp_pkg::PAT_DEPTH - 1) push_op(kmp_pkg::OP_APPEND, 8'h61, 1'b0, 1'b0);
    push_op(kmp_pkg::OP_APPEND, 8'h63, 1'b0, 1'b0);
    repeat (6) push_op(kmp_pkg::OP_APPEND, 8'h64, 1'b0, 1'b0);
    repeat (kmp_pkg::PAT_DEPTH - 1) push_op(kmp_pkg::OP_TEXT, 8'h61, 1'b0, 1'b0);
    push_op(kmp_pkg::OP_TEXT, 8'h62, 1'b0, 1'b0);
    repeat (kmp_pkg::PAT_DEPTH - 1) push_op(kmp_pkg::OP_TEXT, 8'h61, 1'b0, 1'b0);
    push_op(kmp_pkg::OP_TEXT, 8'h63, 1'b1, 1'b0);

    // Unmatched run, back to back, then a match.
    calm_tx = 1'b1;
    push_op(kmp_pkg::OP_CLEAR,  8'h00, 1'b0, 1'b1);
    push_op(kmp_pkg::OP_APPEND, 8'h01, 1'b0, 1'b0);
    push_op(kmp_pkg::OP_APPEND, 8'h02, 1'b0, 1'b0);
    repeat (RUN_TEXT_LEN) push_op(kmp_pkg::OP_TEXT, 8'h00, 1'b0, 1'b0);
    push_op(kmp_pkg::OP_TEXT, 8'h01, 1'b0, 1'b0);
    push_op(kmp_pkg::OP_TEXT, 8'h02, 1'b1, 1'b0);

    random_made = 0;
    n = 0;
    while (random_made < RANDOM_ITEMS) begin
      add_search(n);
      n++;
    end
  endtask

  // ---------------------------------------------------------------------
  // Driver: offers queued transactions, holds payload while stalled.
  // ---------------------------------------------------------------------
  pending_op_t cur_op;
  bit          have_cur = 1'b0;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_data  <= '0;
    end else begin
      if (in_valid && !in_stall) predict_search_outcome(in_data);
      // a stalled offer stays as it is
      if (!(in_valid && in_stall)) begin
        if (!have_cur && pending_ops.size() != 0) begin
          cur_op   = pending_ops.pop_front();
          have_cur = 1'b1;
        end
        if (have_cur && cur_op.gap > 0) begin
          cur_op.gap--;
          in_valid <= 1'b0;
        end else if (have_cur && !(cur_op.wait_empty && expected_outcomes.size() != 0)) begin
          in_valid <= 1'b1;
          in_data  <= cur_op.item;
          have_cur = 1'b0;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Monitor: random stall per result, two long hold-offs, field checks.
  // ---------------------------------------------------------------------
  int                stall_left = 0;
  kmp_pkg::kmp_out_t want;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall  <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_outcomes.size() == 0) begin
          flag_mismatch($sformatf("unexpected result found=%0b position=%0d",
                                  out_data.found, out_data.position));
        end else begin
          want = expected_outcomes.pop_front();
          if (out_data.found !== want.found)
            flag_mismatch($sformatf("result %0d: found %0b, want %0b",
                                    results_seen, out_data.found, want.found));
          if (out_data.position !== want.position)
            flag_mismatch($sformatf("result %0d: position %0d, want %0d",
                                    results_seen, out_data.position, want.position));
        end
        results_seen++;
        // long hold-offs so the output slot fills and the input backs up
        if (results_seen == 25 || results_seen == 60)
          stall_left = HOLD_CYCLES;
        else if ((results_seen / 16) % 3 == 0)
          stall_left = 0;  // stretch without receiver stalls
        else
          stall_left = $urandom_range(0, MAX_GAP);
      end else if (stall_left > 0) begin
        stall_left--;
      end
      out_stall <= (stall_left != 0);
    end
  end

  // Watchdog: too long without any transaction on either side.
  int idle_cycles = 0;

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles = 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("** kmp_substring_search: FAILED **");
      $finish;
    end else begin
      idle_cycles++;
    end
  end

  initial begin
    clear_search_model();
    build_stimulus();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    while (pending_ops.size() != 0 || have_cur || in_valid) @(posedge clk);
    while (expected_outcomes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0)
      $display("** kmp_substring_search: PASSED **");
    else
      $display("** kmp_substring_search: FAILED **");
    $finish;
  end

endmodule
